/* rtl/core/rmsd_pkg.sv */
// Package for the block RMS downsampler: payload structs, queue entry,
// back-end state codes and fixed widths. No dependencies.
package rmsd_pkg;

   // Fixed datapath widths
   localparam int SUM_W       = 60;
   localparam int SQUARE_W    = 48;
   localparam int COUNT_W     = 17;
   localparam int IDX_W       = 10;
   localparam int ROOT_W      = 30;
   localparam int DIV_STEPS   = 60;
   localparam int SQRT_STEPS  = 30;
   localparam int STEP_W      = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int MAX_CELL_ROWS = 4096;

   localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};
   localparam logic [23:0]      VALUE_MAX = 24'hFFFFFF;

   // Configuration register indexes
   localparam logic [2:0] CSR_COLS_PER_BLOCK   = 3'd0;
   localparam logic [2:0] CSR_ROWS_PER_BLOCK   = 3'd1;
   localparam logic [2:0] CSR_CELLS_PER_ROW    = 3'd2;
   localparam logic [2:0] CSR_CELLS_PER_COLUMN = 3'd3;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rmsd_req_type;

   typedef struct packed {
      logic [23:0] cell_value;
      logic [5:0]  cell_column;
      logic        row_done;
      logic        frame_done;
   } rmsd_rsp_type;

   // One classified pixel handed from front to back
   typedef struct packed {
      logic [SQUARE_W-1:0] square;
      logic [COUNT_W-1:0]  count;
      logic [IDX_W-1:0]    idx;
      logic                emit;
      logic                row_done;
      logic                frame_done;
   } rmsd_job_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ACC,
      S_DIV,
      S_SQRT,
      S_OUT
   } rmsd_state_type;

endpackage

/* rtl/core/rmsd_front.sv */
// Front end: configuration registers, block position counters and pixel
// squaring. Depends on rmsd_pkg.
module rmsd_front #(
   parameter int MAX_CELLS_PER_ROW = 64,
   parameter int MAX_BLOCK_SIDE    = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [12:0]           csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rmsd_pkg::rmsd_req_type req_data,
   output logic                  job_valid,
   input  logic                  job_ready,
   output rmsd_pkg::rmsd_job_type job_data
);
   import rmsd_pkg::*;

   localparam int CW = (MAX_BLOCK_SIDE > 1) ? $clog2(MAX_BLOCK_SIDE) : 1;
   localparam int IW = (MAX_CELLS_PER_ROW > 1) ? $clog2(MAX_CELLS_PER_ROW) : 1;
   localparam int BW = $clog2(MAX_BLOCK_SIDE + 1);
   localparam int PW = $clog2(MAX_CELLS_PER_ROW + 1);

   logic [6:0]  cols_ff, rows_ff, cpr_ff;
   logic [12:0] cpc_ff;
   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [11:0]   crow_ff, crow_in;
   logic [BW-1:0] cpb, rpb;
   logic [PW-1:0] cpr;
   logic [12:0]   cpc;
   logic last_col, last_row, last_cell, last_crow, accept;
   logic [23:0] packed_px;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign req_ready = job_ready;
   assign job_valid = req_valid;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= 7'd2;
         rows_ff <= 7'd2;
         cpr_ff  <= 7'd1;
         cpc_ff  <= 13'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_COLS_PER_BLOCK:   cols_ff <= csr_data[6:0];
            CSR_ROWS_PER_BLOCK:   rows_ff <= csr_data[6:0];
            CSR_CELLS_PER_ROW:    cpr_ff  <= csr_data[6:0];
            CSR_CELLS_PER_COLUMN: cpc_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Saturate registers into their ranges
   always_comb begin
      if (cols_ff == 7'd0) cpb = BW'(1);
      else if (32'(cols_ff) > MAX_BLOCK_SIDE) cpb = BW'(MAX_BLOCK_SIDE);
      else cpb = BW'(cols_ff);
      if (rows_ff == 7'd0) rpb = BW'(1);
      else if (32'(rows_ff) > MAX_BLOCK_SIDE) rpb = BW'(MAX_BLOCK_SIDE);
      else rpb = BW'(rows_ff);
      if (cpr_ff == 7'd0) cpr = PW'(1);
      else if (32'(cpr_ff) > MAX_CELLS_PER_ROW) cpr = PW'(MAX_CELLS_PER_ROW);
      else cpr = PW'(cpr_ff);
      if (cpc_ff == 13'd0) cpc = 13'd1;
      else if (32'(cpc_ff) > MAX_CELL_ROWS) cpc = 13'(MAX_CELL_ROWS);
      else cpc = cpc_ff;
   end

   // Classify the pixel position
   assign last_col  = (32'(col_ff) + 32'd1) >= 32'(cpb);
   assign last_row  = (32'(row_ff) + 32'd1) >= 32'(rpb);
   assign last_cell = (32'(pos_ff) + 32'd1) >= 32'(cpr);
   assign last_crow = (32'(crow_ff) + 32'd1) >= 32'(cpc);

   // Advance the position counters
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      pos_in  = pos_ff;
      crow_in = crow_ff;
      if (!last_col) begin
         col_in = col_ff + CW'(1);
      end else begin
         col_in = '0;
         if (!last_cell) begin
            pos_in = pos_ff + IW'(1);
         end else begin
            pos_in = '0;
            if (!last_row) begin
               row_in = row_ff + CW'(1);
            end else begin
               row_in  = '0;
               crow_in = last_crow ? 12'd0 : crow_ff + 12'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         pos_ff  <= '0;
         crow_ff <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         pos_ff  <= pos_in;
         crow_ff <= crow_in;
      end
   end

   // Build the queue entry
   assign packed_px = {req_data.red, req_data.green, req_data.blue};

   always_comb begin
      job_data.square     = SQUARE_W'(packed_px) * SQUARE_W'(packed_px);
      job_data.count      = COUNT_W'(32'(cpb) * 32'(rpb));
      job_data.idx        = IDX_W'(pos_ff);
      job_data.emit       = last_col && last_row;
      job_data.row_done   = last_cell;
      job_data.frame_done = last_cell && last_crow;
   end

endmodule

/* rtl/core/rmsd_queue.sv */
// Short queue of classified pixels between front and back end.
// Depends on rmsd_pkg.
module rmsd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rmsd_pkg::rmsd_job_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rmsd_pkg::rmsd_job_type out_data
);
   import rmsd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   rmsd_job_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ff, rd_ff;
   logic [PTR_W:0]         cnt_ff, cnt_in;
   logic                   push, pop;

   assign in_ready  = cnt_ff != (PTR_W+1)'(QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = slot_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + (PTR_W+1)'(1);
      else if (pop && !push) cnt_in = cnt_ff - (PTR_W+1)'(1);
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= wr_ff + PTR_W'(1);
         if (pop)  rd_ff <= rd_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= in_data;
   end

endmodule

/* rtl/core/rmsd_back.sv */
// Back end: per-column accumulators, serial divider, serial square root
// and output register. Depends on rmsd_pkg.
module rmsd_back #(
   parameter int MAX_CELLS_PER_ROW = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  rmsd_pkg::rmsd_job_type job_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rmsd_pkg::rmsd_rsp_type rsp_data
);
   import rmsd_pkg::*;

   localparam int IW = (MAX_CELLS_PER_ROW > 1) ? $clog2(MAX_CELLS_PER_ROW) : 1;

   rmsd_state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   rmsd_job_type      job_ff;

   logic [SUM_W-1:0]  mem [MAX_CELLS_PER_ROW];
   logic [MAX_CELLS_PER_ROW-1:0] valid_ff;
   logic [SUM_W-1:0]  rd_sum_ff;
   logic              rd_hit_ff;
   logic [IW-1:0]     wr_addr;

   logic [SUM_W-1:0]  sum_now, sum_acc;
   logic [SUM_W:0]    total;

   logic [SUM_W-1:0]  quo_ff;
   logic [COUNT_W-1:0] rem_ff;
   logic [COUNT_W:0]  div_trial;
   logic              div_bit;

   logic [SUM_W-1:0]  src_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [ROOT_W+1:0] srem_ff;
   logic [ROOT_W+3:0] sq_new;
   logic [ROOT_W+3:0] sq_trial;
   logic              sq_bit;

   logic accept, mem_we, div_run, div_last, sqrt_run, sqrt_last, rsp_load, acc_emit;

   assign accept  = job_valid && job_ready;
   assign wr_addr = job_ff.idx[IW-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (job_valid) state_in = S_ACC;
         S_ACC:  state_in = job_ff.emit ? S_DIV : S_IDLE;
         S_DIV:  if (step_ff == STEP_W'(DIV_STEPS - 1)) state_in = S_SQRT;
         S_SQRT: if (step_ff == STEP_W'(SQRT_STEPS - 1)) state_in = S_OUT;
         S_OUT:  if (!rsp_valid || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      job_ready = state_ff == S_IDLE;
      mem_we    = state_ff == S_ACC;
      acc_emit  = (state_ff == S_ACC) && job_ff.emit;
      div_run   = state_ff == S_DIV;
      div_last  = div_run && (step_ff == STEP_W'(DIV_STEPS - 1));
      sqrt_run  = state_ff == S_SQRT;
      sqrt_last = sqrt_run && (step_ff == STEP_W'(SQRT_STEPS - 1));
      rsp_load  = (state_ff == S_OUT) && (!rsp_valid || rsp_ready);
      if ((div_run && !div_last) || (sqrt_run && !sqrt_last))
         step_in = step_ff + STEP_W'(1);
      else
         step_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Latch the job and read its accumulator
   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff    <= job_data;
         rd_sum_ff <= mem[job_data.idx[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_hit_ff <= 1'b0;
      end else if (accept) begin
         rd_hit_ff <= valid_ff[job_data.idx[IW-1:0]];
      end
   end

   // Saturating accumulate
   assign sum_now = rd_hit_ff ? rd_sum_ff : '0;
   assign total   = {1'b0, sum_now} + (SUM_W+1)'(job_ff.square);
   assign sum_acc = total[SUM_W] ? SUM_LIMIT : total[SUM_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= job_ff.emit ? '0 : sum_acc;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (mem_we) valid_ff[wr_addr] <= 1'b1;
   end

   // Restoring divider, one quotient bit per cycle
   assign div_trial = {rem_ff, quo_ff[SUM_W-1]};
   assign div_bit   = div_trial >= {1'b0, job_ff.count};

   always_ff @(posedge clock) begin
      if (acc_emit) begin
         quo_ff <= sum_acc;
         rem_ff <= '0;
      end else if (div_run) begin
         quo_ff <= {quo_ff[SUM_W-2:0], div_bit};
         rem_ff <= div_bit ? COUNT_W'(div_trial - {1'b0, job_ff.count})
                           : div_trial[COUNT_W-1:0];
      end
   end

   // Digit-by-digit square root, two radicand bits per cycle
   assign sq_new   = {srem_ff, src_ff[SUM_W-1:SUM_W-2]};
   assign sq_trial = (ROOT_W+4)'({root_ff, 2'b01});
   assign sq_bit   = sq_new >= sq_trial;

   always_ff @(posedge clock) begin
      if (div_last) begin
         src_ff  <= {quo_ff[SUM_W-2:0], div_bit};
         root_ff <= '0;
         srem_ff <= '0;
      end else if (sqrt_run) begin
         src_ff  <= {src_ff[SUM_W-3:0], 2'b00};
         root_ff <= {root_ff[ROOT_W-2:0], sq_bit};
         srem_ff <= sq_bit ? (ROOT_W+2)'(sq_new - sq_trial) : sq_new[ROOT_W+1:0];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data.cell_value  <= (root_ff[ROOT_W-1:24] != '0) ? VALUE_MAX
                                                              : root_ff[23:0];
         rsp_data.cell_column <= 6'(job_ff.idx);
         rsp_data.row_done    <= job_ff.row_done;
         rsp_data.frame_done  <= job_ff.frame_done;
      end
   end

endmodule

/* rtl/core/block_rms_image_downsample_top.sv */
// Top level of the block RMS downsampler: front end, job queue, back end.
// Depends on rmsd_pkg, rmsd_front, rmsd_queue and rmsd_back.
//
// Pixels enter in raster order; each block of cols_per_block by
// rows_per_block pixels yields one result, the floor square root of the
// mean squared packed color. The front end takes one pixel per cycle
// while its four-entry queue has room. For a pixel that does not close a
// block, the back end reads the accumulator, then writes it back; on a
// block's last pixel it accumulates, divides bit-serially by the pixel
// count, takes the square root and then loads the output register. It
// takes no new pixel until it is idle again, so sustained throughput is
// set by the back end.
// Configuration registers: index 0 cols_per_block, 1 rows_per_block,
// 2 cells_per_row, 3 cells_per_column; write them only while idle.
module block_rms_image_downsample_top #(
   parameter int MAX_CELLS_PER_ROW = 64,
   parameter int MAX_BLOCK_SIDE    = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [12:0]           csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rmsd_pkg::rmsd_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rmsd_pkg::rmsd_rsp_type rsp_data
);
   import rmsd_pkg::*;

   logic         fq_valid, fq_ready, qb_valid, qb_ready;
   rmsd_job_type fq_data, qb_data;

   rmsd_front #(
      .MAX_CELLS_PER_ROW(MAX_CELLS_PER_ROW),
      .MAX_BLOCK_SIDE   (MAX_BLOCK_SIDE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (fq_valid),
      .job_ready (fq_ready),
      .job_data  (fq_data)
   );

   rmsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   rmsd_back #(
      .MAX_CELLS_PER_ROW(MAX_CELLS_PER_ROW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qb_valid),
      .job_ready (qb_ready),
      .job_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/block_rms_image_downsample_top_test.sv */
// Testbench for block_rms_image_downsample_top: directed pixel table, then random frames.
// Uses rmsd_pkg for payload types and register indexes. Table or predictor checks each cell.
`timescale 1ns / 100ps

module block_rms_image_downsample_top_test;
   import rmsd_pkg::*;

   localparam int        PIXEL_TARGET  = 850;
   localparam int        CYCLE_LIMIT   = 1000000;
   localparam int        SETTLE_CYCLES = 150;
   localparam int        CELL_SLOTS    = 64;
   localparam int        SIDE_MAX      = 64;
   localparam logic [2:0] CSR_UNUSED   = 3'd5;

   typedef struct packed {
      logic [23:0] pixel;
      logic        typed;
      logic        emits;
      logic [31:0] want;
   } directed_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [2:0]             csr_index;
   logic [12:0]            csr_data;
   logic                   req_valid;
   logic                   req_ready;
   rmsd_req_type           req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rmsd_rsp_type           rsp_data;

   // Predictor state
   logic [59:0]            cell_sums [CELL_SLOTS];
   int unsigned            col_in_block;
   int unsigned            cell_col;
   int unsigned            row_in_block;
   int unsigned            cell_row;
   logic [6:0]             reg_cols;
   logic [6:0]             reg_rows;
   logic [6:0]             reg_cells_row;
   logic [12:0]            reg_cells_col;

   rmsd_rsp_type           pending_cells [$];
   int                     pixels_sent;
   int                     cells_seen;
   int                     errors;
   int                     phases_run;
   longint                 cycle_count;
   bit                     hold_request;

   directed_row_type       directed_rows [20];

   block_rms_image_downsample_top DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Floor square root by building the root one bit at a time
   function automatic logic [63:0] floor_root(logic [63:0] x);
      logic [63:0] root;
      logic [63:0] trial;
      root = 0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= x) root = trial;
      end
      return root;
   endfunction

   task automatic reset_cells();
      foreach (cell_sums[i]) cell_sums[i] = '0;
      col_in_block  = 0;
      cell_col      = 0;
      row_in_block  = 0;
      cell_row      = 0;
      reg_cols      = 7'd2;
      reg_rows      = 7'd2;
      reg_cells_row = 7'd1;
      reg_cells_col = 13'd1;
   endtask

   task automatic apply_register(logic [2:0] index, logic [12:0] value);
      case (index)
         CSR_COLS_PER_BLOCK:   reg_cols      = value[6:0];
         CSR_ROWS_PER_BLOCK:   reg_rows      = value[6:0];
         CSR_CELLS_PER_ROW:    reg_cells_row = value[6:0];
         CSR_CELLS_PER_COLUMN: reg_cells_col = value;
         default: ;
      endcase
   endtask

   // Accumulate one pixel and report the cell it closes, if any
   task automatic accumulate_pixel(input rmsd_req_type px, output bit closes,
                                   output rmsd_rsp_type result);
      int unsigned cpb, rpb, cpr, cpc, idx;
      logic [63:0] packed_px, sq, mean, root;
      bit last_col, last_row, last_cell, last_cell_row;
      cpb = clamp_reg(reg_cols, SIDE_MAX);
      rpb = clamp_reg(reg_rows, SIDE_MAX);
      cpr = clamp_reg(reg_cells_row, CELL_SLOTS);
      cpc = clamp_reg(reg_cells_col, MAX_CELL_ROWS);
      packed_px = {40'd0, px.red, px.green, px.blue};
      sq = packed_px * packed_px;
      idx = (cell_col >= CELL_SLOTS) ? CELL_SLOTS - 1 : cell_col;
      if ({4'd0, cell_sums[idx]} > {4'd0, SUM_LIMIT} - sq) cell_sums[idx] = SUM_LIMIT;
      else cell_sums[idx] = cell_sums[idx] + sq[59:0];
      last_col      = col_in_block + 1 >= cpb;
      last_row      = row_in_block + 1 >= rpb;
      last_cell     = idx + 1 >= cpr;
      last_cell_row = cell_row + 1 >= cpc;
      closes = 0;
      result = '0;
      if (last_col && last_row) begin
         mean = {4'd0, cell_sums[idx]} / (64'(cpb) * 64'(rpb));
         root = floor_root(mean);
         if (root > 64'hFFFFFF) root = 64'hFFFFFF;
         cell_sums[idx] = '0;
         result.cell_value  = root[23:0];
         result.cell_column = idx[5:0];
         result.row_done    = last_cell;
         result.frame_done  = last_cell && last_cell_row;
         closes = 1;
      end
      // Advance the raster position
      if (!last_col) begin
         col_in_block++;
      end else begin
         col_in_block = 0;
         if (!last_cell) begin
            cell_col = idx + 1;
         end else begin
            cell_col = 0;
            if (!last_row) begin
               row_in_block++;
            end else begin
               row_in_block = 0;
               cell_row = last_cell_row ? 0 : cell_row + 1;
            end
         end
      end
   endtask

   task automatic write_register(logic [2:0] index, logic [12:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      apply_register(index, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(int cols, int rows, int cells_row, int cells_col);
      write_register(CSR_COLS_PER_BLOCK, 13'(cols));
      write_register(CSR_ROWS_PER_BLOCK, 13'(rows));
      write_register(CSR_CELLS_PER_ROW, 13'(cells_row));
      write_register(CSR_CELLS_PER_COLUMN, 13'(cells_col));
      phases_run++;
   endtask

   // Offer a pixel and hold it until the transfer; optionally idle afterward
   task automatic send_pixel(rmsd_req_type px, bit typed, bit emits, rmsd_rsp_type want);
      bit closes;
      rmsd_rsp_type result;
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (!req_ready);
      accumulate_pixel(px, closes, result);
      if (typed) begin
         if (emits) pending_cells.push_back(want);
      end else if (closes) begin
         pending_cells.push_back(result);
      end
      pixels_sent++;
      gap = $urandom_range(0, 99);
      gap = (gap < 60) ? 0 : (gap < 92) ? $urandom_range(1, 3) : $urandom_range(5, 30);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic rmsd_req_type random_pixel();
      rmsd_req_type px;
      px = rmsd_req_type'(24'($urandom));
      case ($urandom_range(0, 7))
         0: px = '1;
         1: px = '0;
         2: px.red = 8'hFF;
         default: ;
      endcase
      return px;
   endfunction

   task automatic drain_and_settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_run(int count);
      for (int i = 0; i < count; i++) send_pixel(random_pixel(), 1'b0, 1'b0, '0);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Receiver: random stalls, with one long hold on request
   initial begin
      int pick;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 0;
            rsp_ready <= 1'b0;
            repeat (400) @(negedge clock);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               rsp_ready <= 1'b1;
               @(negedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat ((pick < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40))
                  @(negedge clock);
            end
         end
      end
   end

   // Compare each delivered cell with the oldest prediction
   always @(posedge clock) begin
      rmsd_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         cells_seen++;
         if (pending_cells.size() == 0) begin
            $error("cell with no prediction waiting: %h", rsp_data);
            errors++;
         end else begin
            want = pending_cells.pop_front();
            if (rsp_data.cell_value !== want.cell_value) begin
               $error("cell_value expected %h actual %h", want.cell_value, rsp_data.cell_value);
               errors++;
            end
            if (rsp_data.cell_column !== want.cell_column) begin
               $error("cell_column expected %0d actual %0d",
                      want.cell_column, rsp_data.cell_column);
               errors++;
            end
            if (rsp_data.row_done !== want.row_done) begin
               $error("row_done expected %b actual %b", want.row_done, rsp_data.row_done);
               errors++;
            end
            if (rsp_data.frame_done !== want.frame_done) begin
               $error("frame_done expected %b actual %b", want.frame_done, rsp_data.frame_done);
               errors++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      rmsd_req_type px;
      reset       = 1'b1;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      req_valid   = 1'b0;
      req_data    = '0;
      pixels_sent = 0;
      cells_seen  = 0;
      errors      = 0;
      phases_run  = 0;
      cycle_count = 0;
      hold_request = 0;
      reset_cells();

      // Reset geometry is 2x2 blocks, one cell per row and frame
      directed_rows = '{
         '{24'hFFFFFF, 1'b1, 1'b0, 32'h0},
         '{24'hFFFFFF, 1'b1, 1'b0, 32'h0},
         '{24'hFFFFFF, 1'b1, 1'b0, 32'h0},
         '{24'hFFFFFF, 1'b1, 1'b1, {24'hFFFFFF, 6'd0, 1'b1, 1'b1}},
         '{24'h000000, 1'b1, 1'b0, 32'h0},
         '{24'h000000, 1'b1, 1'b0, 32'h0},
         '{24'h000000, 1'b1, 1'b0, 32'h0},
         '{24'h000000, 1'b1, 1'b1, {24'h000000, 6'd0, 1'b1, 1'b1}},
         '{24'h000001, 1'b1, 1'b0, 32'h0},
         '{24'h000001, 1'b1, 1'b0, 32'h0},
         '{24'h000001, 1'b1, 1'b0, 32'h0},
         '{24'h000001, 1'b1, 1'b1, {24'h000001, 6'd0, 1'b1, 1'b1}},
         '{24'hFF0000, 1'b0, 1'b0, 32'h0},
         '{24'h00FF00, 1'b0, 1'b0, 32'h0},
         '{24'h0000FF, 1'b0, 1'b0, 32'h0},
         '{24'h800080, 1'b0, 1'b0, 32'h0},
         '{24'h7F7F7F, 1'b0, 1'b0, 32'h0},
         '{24'h010203, 1'b0, 1'b0, 32'h0},
         '{24'hFEDCBA, 1'b0, 1'b0, 32'h0},
         '{24'hAAAAAA, 1'b0, 1'b0, 32'h0}
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table at reset geometry
      foreach (directed_rows[i]) begin
         px = rmsd_req_type'(directed_rows[i].pixel);
         send_pixel(px, directed_rows[i].typed, directed_rows[i].emits,
                    rmsd_rsp_type'(directed_rows[i].want));
      end
      drain_and_settle();

      // Unused index must leave the geometry alone
      write_register(CSR_UNUSED, 13'h1FFF);
      random_run(8);
      drain_and_settle();

      // Extremes: single-pixel cells, widest row, tall and wide blocks, saturation
      configure(1, 1, 1, 1);
      random_run(30);
      drain_and_settle();
      configure(1, 1, 64, 4096);
      hold_request = 1;
      random_run(90);
      drain_and_settle();
      configure(64, 1, 1, 1);
      random_run(70);
      drain_and_settle();
      configure(1, 64, 1, 2);
      random_run(70);
      drain_and_settle();
      configure(0, 0, 0, 0);
      random_run(20);
      drain_and_settle();
      configure(100, 1, 127, 8191);
      random_run(40);
      drain_and_settle();

      // Random geometries, mostly small, with frames left unfinished between phases
      while (pixels_sent < PIXEL_TARGET) begin
         if ($urandom_range(0, 9) == 0)
            configure($urandom_range(0, 127), $urandom_range(1, 8),
                      $urandom_range(0, 127), $urandom_range(0, 8191));
         else
            configure($urandom_range(1, 4), $urandom_range(1, 4),
                      $urandom_range(1, 8), $urandom_range(1, 4));
         random_run($urandom_range(40, 80));
         drain_and_settle();
      end

      $display("Covered %0d pixels over %0d geometry phases, %0d cells checked.",
               pixels_sent, phases_run, cells_seen);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
